// File: rtl/core/mgt_pkg.sv
// Shared types and constants for the multichannel gate timer.
// Holds field widths, function and phase codes, register indexes and the
// command and status structs between controller and datapath. No dependencies.
package mgt_pkg;

	// Sizing of the channel set and the note table.
	localparam int CHANNELS    = 4;
	localparam int TABLE_DEPTH = 16;
	localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Field widths.
	localparam int FUNC_W  = 2;
	localparam int PIN_W   = 8;
	localparam int VAL_W   = 16;
	localparam int TIME_W  = 32;
	localparam int TIDX_W  = 4;
	localparam int TSZ_W   = 5;
	localparam int NOTE_W  = 8;
	localparam int NBIT_W  = $clog2(NOTE_W);
	localparam int CH_W    = 2;
	localparam int MASK_W  = 4;
	localparam int PWM_W   = 8;

	// Stream and configuration port widths.
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;

	// Configuration register indexes.
	localparam int NUM_PIN_REGS = 4;
	localparam logic [CFG_IDX_W-1:0] REG_PIN0       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIN1       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIN2       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIN3       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 3'd4;
	localparam logic [TSZ_W-1:0]     TSZ_RESET      = 5'd16;

	// Input item kinds.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_GATE   = 2'd1,
		FUNC_NOTE   = 2'd2,
		FUNC_TBL_WR = 2'd3
	} func_t;

	// Per-channel phase.
	typedef enum logic [1:0] {
		PH_WAITING  = 2'd0,
		PH_RUNNING  = 2'd1,
		PH_FINISHED = 2'd2
	} phase_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK,
		ST_FIND,
		ST_DIV,
		ST_READ,
		ST_WRITE,
		ST_DONE
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic              load;
		logic              tick_step;
		logic              arm;
		logic              note_hit;
		logic              div_step;
		logic              tbl_wr;
		logic              tbl_rd;
		logic              out_load;
		logic [CH_W-1:0]   ch;
		logic [NBIT_W-1:0] bit_sel;
	} mgt_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		func_t func;
		logic  match;
		logic  out_free;
	} mgt_status_t;

endpackage

// File: rtl/core/mgt_ctrl.sv
// Controller state machine of the gate timer: sequences channel scans,
// the remainder unit, note table access and result hand-off.
// Depends on mgt_pkg.
module mgt_ctrl import mgt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  mgt_status_t status,
	output mgt_cmd_t    cmd
);

	state_t              state_q, state_d;
	logic [CH_W-1:0]     ch_q;
	logic [NBIT_W-1:0]   bit_q;
	logic                ch_last;

	assign ch_last = (ch_q == CH_W'(CHANNELS - 1));

	// State register and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					ch_q <= '0;
				end
				ST_TICK: begin
					ch_q <= ch_q + CH_W'(1);
				end
				ST_FIND: begin
					ch_q  <= ch_q + CH_W'(1);
					bit_q <= NBIT_W'(NOTE_W - 1);
				end
				ST_DIV: begin
					bit_q <= bit_q - NBIT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (status.func)
					FUNC_TICK:   state_d = ST_TICK;
					FUNC_GATE:   state_d = ST_FIND;
					FUNC_NOTE:   state_d = ST_FIND;
					FUNC_TBL_WR: state_d = ST_WRITE;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_TICK: begin
				if (ch_last) state_d = ST_DONE;
			end
			ST_FIND: begin
				if (status.match) begin
					state_d = (status.func == FUNC_NOTE) ? ST_DIV : ST_DONE;
				end else if (ch_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (bit_q == '0) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_WRITE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands and handshake.
	always_comb begin
		cmd         = '0;
		cmd.ch      = ch_q;
		cmd.bit_sel = bit_q;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_TICK: begin
				cmd.tick_step = 1'b1;
			end
			ST_FIND: begin
				cmd.arm      = status.match && (status.func == FUNC_GATE);
				cmd.note_hit = status.match && (status.func == FUNC_NOTE);
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_READ: begin
				cmd.tbl_rd = 1'b1;
			end
			ST_WRITE: begin
				cmd.tbl_wr = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/mgt_datapath.sv
// Datapath of the gate timer: configuration registers, channel state,
// shared time comparator, bit-serial remainder unit, note table and result register.
// Depends on mgt_pkg.
module mgt_datapath import mgt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mgt_cmd_t               cmd,
	output mgt_status_t            status,
	input  logic [FUNC_W-1:0]      in_func,
	input  logic [IN_TDATA_W-1:0]  in_data,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic                   out_user
);

	// Configuration registers.
	logic [PIN_W-1:0]  pin_cfg_q [NUM_PIN_REGS];
	logic [TSZ_W-1:0]  tsize_q;

	// Captured input item.
	func_t             func_q;
	logic [PIN_W-1:0]  pin_q;
	logic [VAL_W-1:0]  value_q;
	logic [TIME_W-1:0] now_q;
	logic [TIDX_W-1:0] tidx_q;

	// Channel state.
	logic [TIME_W-1:0] start_q [CHANNELS];
	logic [TIME_W-1:0] end_q   [CHANNELS];
	phase_t            phase_q [CHANNELS];
	logic              level_q [CHANNELS];
	logic [NOTE_W-1:0] note_q  [CHANNELS];

	// Per-item result state.
	logic [MASK_W-1:0] changed_q;
	logic              found_q;
	logic              pwm_valid_q;
	logic [CH_W-1:0]   pwm_ch_q;
	logic [PWM_W-1:0]  pwm_val_q;
	logic [TSZ_W-1:0]  rem_q;

	// Note table.
	logic [PWM_W-1:0]  tbl_mem [TABLE_DEPTH];

	// Result register.
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_user_q;

	logic [MASK_W-1:0] levels;
	logic [TSZ_W-1:0]  size_eff;
	logic [TSZ_W-1:0]  rem_shift;
	logic [NOTE_W-1:0] note_in;

	assign note_in = value_q[NOTE_W-1:0];

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PIN_REGS; i++) begin
				pin_cfg_q[i] <= PIN_W'(i);
			end
			tsize_q <= TSZ_RESET;
		end else if (cfg_we) begin
			if (cfg_index < REG_TABLE_SIZE) begin
				pin_cfg_q[cfg_index[CH_W-1:0]] <= cfg_data[PIN_W-1:0];
			end else if (cfg_index == REG_TABLE_SIZE) begin
				tsize_q <= cfg_data[TSZ_W-1:0];
			end
		end
	end

	// Effective divisor: zero counts as one, large values clamp to the depth.
	always_comb begin
		if (tsize_q == '0) begin
			size_eff = TSZ_W'(1);
		end else if (32'(tsize_q) > 32'(TABLE_DEPTH)) begin
			size_eff = TSZ_W'(TABLE_DEPTH);
		end else begin
			size_eff = tsize_q;
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func_t'(in_func);
			pin_q   <= in_data[PIN_W-1:0];
			value_q <= in_data[PIN_W +: VAL_W];
			now_q   <= in_data[PIN_W+VAL_W +: TIME_W];
			tidx_q  <= in_data[PIN_W+VAL_W+TIME_W +: TIDX_W];
		end
	end

	// Status toward the controller.
	assign status.func     = func_q;
	assign status.match    = (pin_cfg_q[cmd.ch] == pin_q);
	assign status.out_free = !out_valid_q || out_ready;

	// Channel updates: one channel per step on ticks, one arm on a match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				start_q[c] <= '0;
				end_q[c]   <= '0;
				phase_q[c] <= PH_FINISHED;
				level_q[c] <= 1'b0;
				note_q[c]  <= '0;
			end
		end else begin
			if (cmd.tick_step) begin
				case (phase_q[cmd.ch])
					PH_WAITING: begin
						if (start_q[cmd.ch] <= now_q) begin
							level_q[cmd.ch] <= 1'b1;
							phase_q[cmd.ch] <= PH_RUNNING;
						end
					end
					PH_RUNNING: begin
						if (end_q[cmd.ch] <= now_q) begin
							level_q[cmd.ch] <= 1'b0;
							phase_q[cmd.ch] <= PH_FINISHED;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.arm) begin
				start_q[cmd.ch] <= now_q;
				end_q[cmd.ch]   <= now_q + TIME_W'(value_q);
				phase_q[cmd.ch] <= PH_WAITING;
			end
			if (cmd.note_hit) begin
				note_q[cmd.ch] <= note_in;
			end
		end
	end

	// One remainder bit per step: shift in the next note bit, subtract if it fits.
	assign rem_shift = {rem_q[TSZ_W-2:0], note_in[cmd.bit_sel]};

	// Per-item result flags and the remainder register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			changed_q   <= '0;
			found_q     <= 1'b0;
			pwm_valid_q <= 1'b0;
			pwm_ch_q    <= '0;
			rem_q       <= '0;
		end else begin
			if (cmd.tick_step) begin
				if ((phase_q[cmd.ch] == PH_WAITING) && (start_q[cmd.ch] <= now_q) &&
				    !level_q[cmd.ch]) begin
					changed_q[cmd.ch] <= 1'b1;
				end
				if ((phase_q[cmd.ch] == PH_RUNNING) && (end_q[cmd.ch] <= now_q) &&
				    level_q[cmd.ch]) begin
					changed_q[cmd.ch] <= 1'b1;
				end
			end
			if (cmd.arm) begin
				found_q <= 1'b1;
			end
			if (cmd.note_hit) begin
				found_q     <= 1'b1;
				pwm_valid_q <= 1'b1;
				pwm_ch_q    <= cmd.ch;
			end
			if (cmd.div_step) begin
				rem_q <= (rem_shift >= size_eff) ? (rem_shift - size_eff) : rem_shift;
			end
		end
	end

	// Note table write port.
	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && (32'(tidx_q) < 32'(TABLE_DEPTH))) begin
			tbl_mem[TBL_AW'(tidx_q)] <= value_q[PWM_W-1:0];
		end
	end

	// Note table registered read.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pwm_val_q <= '0;
		end else if (cmd.tbl_rd) begin
			pwm_val_q <= tbl_mem[TBL_AW'(rem_q)];
		end
	end

	// Gate level mask, unused channel bits read as zero.
	always_comb begin
		levels = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			levels[c] = level_q[c];
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {5'b0, found_q, pwm_val_q, pwm_ch_q, changed_q, levels};
			out_user_q <= pwm_valid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

// File: rtl/core/multichannel_gate_timer_unit.sv
// Top level of the multichannel gate timer: stream ports, configuration port,
// controller and datapath. Depends on mgt_pkg, mgt_ctrl and mgt_datapath.
//
// The block keeps four gate channels, each named by a configured pin, and takes
// one item at a time from its input stream, giving exactly one result per item.
// A tick visits every channel in turn, since one shared 32-bit comparator
// visits one channel per cycle. A gate command searches the channels in order
// and stops at the first one whose pin matches, or after the last channel when
// no pin matches. A note command does the same search; after it an 8-step
// bit-serial remainder unit reduces the note by the table size and the note
// table is read through its registered port. Results wait in an output
// register, so a stalled output delays only the hand-off of the next result.
// Configuration writes are always taken and must only be issued while the block
// is idle.
module multichannel_gate_timer_unit import mgt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: pin[7:0], value[23:8], now_ms[55:24], table_index[59:56], zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: func[1:0]
	input  logic [FUNC_W-1:0]      s_axis_tuser,
	// Result stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata: gate_levels[3:0], gate_changed[7:4], pwm_channel[9:8],
	//        pwm_value[17:10], pin_found[18], zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// tuser: pwm_valid[0]
	output logic                   m_axis_tuser,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	mgt_cmd_t    cmd;
	mgt_status_t status;

	// Register writes are always accepted.
	assign cfg_ready = 1'b1;

	// Sequencer.
	mgt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Channel state, arithmetic, note table and result register.
	mgt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_func   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

// File: rtl/core/mgt_checker.sv
// Port-level checks for the multichannel gate timer, bound to the top level.
// Depends on mgt_pkg and multichannel_gate_timer_unit.
module mgt_checker import mgt_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))
		else $error("result changed while stalled");

	// After a transaction the block is busy with that item and drops ready.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted again without processing");

	// A PWM value is only emitted for a command that found its pin.
	a_pwm_needs_pin: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[18])
		else $error("pwm_valid without pin_found");

	// Without a PWM value the channel and value fields are zero.
	a_pwm_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[17:8] == 10'd0))
		else $error("pwm fields set without pwm_valid");

endmodule

bind multichannel_gate_timer_unit mgt_checker u_mgt_checker (.*);
